// ----- rtl/tea_pkg.sv -----
// shared constants and the round mixing function for the tea block cipher
// no dependencies; used by tea_block_cipher
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

  // key schedule constant
  localparam logic [31:0] Delta = 32'h9E37_79B9;

  // default round count
  localparam int unsigned RoundsDefault = 32;

  // key register reset values, key bytes 01..10 packed little-endian
  localparam logic [31:0] KeyWord0Reset = 32'h0403_0201;
  localparam logic [31:0] KeyWord1Reset = 32'h0807_0605;
  localparam logic [31:0] KeyWord2Reset = 32'h0C0B_0A09;
  localparam logic [31:0] KeyWord3Reset = 32'h100F_0E0D;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgKeyWord0 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyWord1 = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyWord2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyWord3 = 2'd3;

  // command codes
  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  // ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb)
  function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] s,
                                      input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] t_a;
    logic [31:0] t_b;
    logic [31:0] t_c;
    t_a = (x << 4) + ka;
    t_b = x + s;
    t_c = (x >> 5) + kb;
    return t_a ^ t_b ^ t_c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tea_block_cipher.sv -----
// tea block cipher, fully unrolled half-round pipeline
// depends on tea_pkg for constants and the mixing function
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel: in_valid_i with cmd_i (0 encrypt, 1 decrypt), block_left_i and
//   block_right_i; a transfer happens on a rising edge with in_valid_i high and
//   in_stall_o low
// - output channel: out_valid_o with out_left_o and out_right_o; a transfer
//   happens on a rising edge with out_valid_o high and out_stall_i low
// - key: four 32-bit words written through cfg_we_i / cfg_idx_i / cfg_data_i;
//   the user must write them only while the pipeline is empty, which the block
//   does not enforce; there is no read-back
// - one register stage per half-round, each with one mix and one add or subtract
// - throughput: one block per cycle while the receiver does not stall
// - stall: the whole pipeline holds when the output register is full and
//   stalled; in_stall_o then goes high, nothing is dropped or repeated
// - reset: all stage valid bits clear, key words return to the default key
module tea_block_cipher #(
  parameter int unsigned ROUNDS = tea_pkg::RoundsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [tea_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                cfg_data_i,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       cmd_i,
  input  wire logic [31:0]                block_left_i,
  input  wire logic [31:0]                block_right_i,
  // output channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [31:0]                     out_left_o,
  output logic [31:0]                     out_right_o
);

  localparam int unsigned NStages = 2 * ROUNDS;

  // key registers
  logic [31:0] key0_q, key1_q, key2_q, key3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= tea_pkg::KeyWord0Reset;
      key1_q <= tea_pkg::KeyWord1Reset;
      key2_q <= tea_pkg::KeyWord2Reset;
      key3_q <= tea_pkg::KeyWord3Reset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tea_pkg::CfgKeyWord0: key0_q <= cfg_data_i;
        tea_pkg::CfgKeyWord1: key1_q <= cfg_data_i;
        tea_pkg::CfgKeyWord2: key2_q <= cfg_data_i;
        tea_pkg::CfgKeyWord3: key3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline state, one entry per half-round
  logic [NStages-1:0] valid_q;
  logic               cmd_q   [NStages];
  logic [31:0]        left_q  [NStages];
  logic [31:0]        right_q [NStages];

  // global advance: the whole pipe moves unless the output register is held
  logic adv;
  assign adv        = !(valid_q[NStages-1] && out_stall_i);
  assign in_stall_o = !adv;

  for (genvar j = 0; j < NStages; j++) begin : g_stage
    // round number and which half of the round this stage does
    localparam int unsigned Round = j / 2;
    localparam bit          SecondHalf = (j % 2) == 1;
    // round sums, fixed per stage
    localparam logic [31:0] SumEnc = 32'(tea_pkg::Delta * 32'(Round + 1));
    localparam logic [31:0] SumDec = 32'(tea_pkg::Delta * 32'(ROUNDS - Round));

    logic        stage_valid;
    logic        stage_cmd;
    logic [31:0] stage_left;
    logic [31:0] stage_right;
    logic        is_dec;
    logic        upd_left;
    logic [31:0] src;
    logic [31:0] mix_val;
    logic [31:0] sum;
    logic [31:0] ka, kb;
    logic [31:0] tgt;
    logic [31:0] tgt_new;

    if (j == 0) begin : g_first
      assign stage_valid = in_valid_i;
      assign stage_cmd   = cmd_i;
      assign stage_left  = block_left_i;
      assign stage_right = block_right_i;
    end else begin : g_next
      assign stage_valid = valid_q[j-1];
      assign stage_cmd   = cmd_q[j-1];
      assign stage_left  = left_q[j-1];
      assign stage_right = right_q[j-1];
    end

    // encrypt: first half updates left, second updates right;
    // decrypt runs the halves the other way round
    always_comb begin
      is_dec   = (stage_cmd == tea_pkg::CmdDecrypt);
      upd_left = (is_dec == SecondHalf);
      src      = upd_left ? stage_right : stage_left;
      tgt      = upd_left ? stage_left  : stage_right;
      ka       = upd_left ? key0_q : key2_q;
      kb       = upd_left ? key1_q : key3_q;
      sum      = is_dec ? SumDec : SumEnc;
      mix_val  = tea_pkg::mix(src, sum, ka, kb);
      tgt_new  = is_dec ? (tgt - mix_val) : (tgt + mix_val);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (adv) begin
        valid_q[j] <= stage_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cmd_q[j]   <= stage_cmd;
        left_q[j]  <= upd_left ? tgt_new : stage_left;
        right_q[j] <= upd_left ? stage_right : tgt_new;
      end
    end
  end

  assign out_valid_o = valid_q[NStages-1];
  assign out_left_o  = left_q[NStages-1];
  assign out_right_o = right_q[NStages-1];

  // an accepted block always occupies the first stage next cycle
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted block did not enter the pipeline");

  // a held pipeline keeps every valid bit
  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("valid bits changed while the pipeline was held");

  // on advance the output takes the valid of the stage before it
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_valid_o == $past(valid_q[NStages-2])))
    else $error("output valid does not follow the last stage");

  // stalling input only when a result is waiting and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

endmodule

`default_nettype wire
